/* rtl/sprite_scanline_sequencer_top_macros.svh */
// Assertion macros for the sprite scanline sequencer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SPRITE_SCANLINE_SEQUENCER_TOP_MACROS_SVH
`define SPRITE_SCANLINE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define SSQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssq_pkg.sv */
// Types, codes and constants of the sprite scanline sequencer.
// No dependencies.
`default_nettype none
package ssq_pkg;

  localparam int ROW_COUNT = 10;
  localparam int LAST_ACTIVE_LINE = 269;
  localparam int ROW_AW = $clog2(ROW_COUNT);

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ROW_FIRST = 5'd1;
  localparam logic [4:0] PH_ROW_LAST = 5'(ROW_COUNT);
  localparam logic [4:0] PH_GAP_LOAD = 5'(ROW_COUNT + 1);
  localparam logic [4:0] PH_GAP_WAIT = 5'(ROW_COUNT + 2);
  localparam logic [4:0] PH_REP_FIRST = 5'(ROW_COUNT + 3);
  localparam logic [4:0] PH_REP_END = 5'(2 * ROW_COUNT + 3);

  localparam logic [8:0] LINE_LAST = 9'(LAST_ACTIVE_LINE);
  localparam logic [7:0] GAP_NONE = 8'd255;
  localparam logic [8:0] GAP_REPEAT_MAX = 9'd252;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_ROW_WR = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  localparam logic [2:0] CFG_X_FIRST = 3'd0;
  localparam logic [2:0] CFG_Y_FIRST = 3'd1;
  localparam logic [2:0] CFG_X_REPEAT = 3'd2;
  localparam logic [2:0] CFG_Y_GAP = 3'd3;
  localparam logic [2:0] CFG_SIZE_CODE = 3'd4;
  localparam logic [2:0] CFG_SPRITE_COLOR = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] line;
    logic [3:0] row_index;
    logic [7:0] row_data;
  } ssq_in_t;

  typedef struct packed {
    logic       draw;
    logic [7:0] row_bits;
    logic [7:0] x_start;
    logic [3:0] pixel_scale;
    logic [2:0] object_color;
    logic       copy_done;
    logic       finished_flag;
  } ssq_out_t;

  typedef struct packed {
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_repeat;
    logic [7:0] y_gap;
    logic [1:0] size_code;
    logic [2:0] sprite_color;
  } ssq_cfg_t;

endpackage
`default_nettype wire

/* rtl/sprite_scanline_sequencer_top.sv */
// Top level of the sprite scanline sequencer: channel registers and config.
// Depends on ssq_pkg, ssq_seq and sprite_scanline_sequencer_top_macros.svh.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o ssq_in_t
//   out      output     out_valid_o/stall_i   ssq_out_t
//   cfg      input      cfg_valid_i/ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; items go to in_q, then results to out_q.
// The sequencer step is combinational between the input and result registers.
// Reset clears the phase, counters, sticky flag and config; rows stay unknown.
// A stalled result holds; the input register then holds its item and raises in_stall_o.
// Config writes are always ready.
`default_nettype none
`include "sprite_scanline_sequencer_top_macros.svh"
module sprite_scanline_sequencer_top
  import ssq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire ssq_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ssq_out_t        out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  ssq_in_t  in_q;
  logic     in_vld_q;
  ssq_out_t out_q;
  logic     out_vld_q;
  ssq_cfg_t cfg_q;
  ssq_out_t result;
  logic     adv;
  logic     in_xfer;

  assign adv = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;
  assign cfg_ready_o = 1'b1;

  ssq_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_X_FIRST:      cfg_q.x_first <= cfg_data_i;
        CFG_Y_FIRST:      cfg_q.y_first <= cfg_data_i;
        CFG_X_REPEAT:     cfg_q.x_repeat <= cfg_data_i;
        CFG_Y_GAP:        cfg_q.y_gap <= cfg_data_i;
        CFG_SIZE_CODE:    cfg_q.size_code <= cfg_data_i[1:0];
        CFG_SPRITE_COLOR: cfg_q.sprite_color <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  `SSQ_ASSERT_NOW(a_fin_sets_flag, out_valid_o && out_data_o.copy_done, out_data_o.finished_flag, "copy done without sticky flag")
  `SSQ_ASSERT_NOW(a_idle_scale, out_valid_o && !out_data_o.draw, out_data_o.pixel_scale == 4'd1 && out_data_o.x_start == 8'd0, "idle result not neutral")
  `SSQ_ASSERT_NEXT(a_in_hold, in_vld_q && !adv, in_vld_q, "input register lost an item")
  `SSQ_ASSERT_NEXT(a_adv_out, adv, out_vld_q, "step did not reach result register")

endmodule
`default_nettype wire

/* rtl/ssq_seq.sv */
// Sequencer state, bitmap row store and per-item step logic.
// Depends on ssq_pkg.
`default_nettype none
module ssq_seq
  import ssq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire ssq_in_t  item_i,
  input  wire ssq_cfg_t cfg_i,
  output ssq_out_t      result_o
);

  logic [4:0] phase_q, phase_d;
  logic [7:0] vcount_q, vcount_d;
  logic [2:0] rcount_q, rcount_d;
  logic       fsticky_q, fsticky_d;
  logic [7:0] rows_q [ROW_COUNT];
  logic [ROW_AW-1:0] rd_idx;
  logic       row_wr;

  assign row_wr = step_i && (item_i.action == ACT_ROW_WR)
                  && (item_i.row_index < 4'(ROW_COUNT));

  always_comb begin
    logic [3:0] scale;
    logic [3:0] nxt;
    logic [8:0] gap_v;
    logic       go;
    logic       use_x_rep;
    logic       drw;
    logic       fnow;
    scale = 4'd1 << cfg_i.size_code;
    phase_d = phase_q;
    vcount_d = vcount_q;
    rcount_d = rcount_q;
    fsticky_d = fsticky_q;
    rd_idx = '0;
    go = 1'b1;
    use_x_rep = 1'b0;
    drw = 1'b0;
    fnow = 1'b0;
    nxt = '0;
    gap_v = '0;
    result_o = '0;
    result_o.finished_flag = fsticky_q;
    case (item_i.action)
      ACT_TICK: begin
        if (item_i.line == 9'd0) begin
          vcount_d = cfg_i.y_first;
          phase_d = PH_IDLE;
          rcount_d = 3'd0;
          fsticky_d = 1'b0;
        end
        if (item_i.line <= LINE_LAST) begin
          if (phase_d == PH_IDLE && item_i.line == {1'b0, vcount_d} + 9'd2) begin
            phase_d = PH_ROW_FIRST;
          end
          if (phase_d >= PH_ROW_FIRST && phase_d <= PH_ROW_LAST) begin
            drw = 1'b1;
            rd_idx = ROW_AW'(phase_d - PH_ROW_FIRST);
            nxt = {1'b0, rcount_d} + 4'd1;
            if (nxt >= scale) begin
              rcount_d = 3'd0;
              phase_d = phase_d + 5'd1;
              if (phase_d > PH_ROW_LAST) begin
                fsticky_d = 1'b1;
                fnow = 1'b1;
              end
            end else begin
              rcount_d = nxt[2:0];
            end
          end else if (phase_d >= PH_GAP_LOAD && phase_d < PH_REP_END) begin
            if (phase_d == PH_GAP_LOAD) begin
              gap_v = (cfg_i.y_gap == GAP_NONE) ? 9'd0 : {1'b0, cfg_i.y_gap} + 9'd1;
              vcount_d = gap_v[7:0];
              if (gap_v > GAP_REPEAT_MAX) begin
                go = 1'b0;
              end else begin
                rcount_d = 3'd0;
                phase_d = PH_GAP_WAIT;
              end
            end
            if (go && phase_d == PH_GAP_WAIT) begin
              if (vcount_d != 8'd0) begin
                vcount_d = vcount_d - 8'd1;
                go = 1'b0;
              end else begin
                phase_d = PH_REP_FIRST;
              end
            end
            if (go && phase_d >= PH_REP_FIRST && phase_d < PH_REP_END) begin
              drw = 1'b1;
              use_x_rep = 1'b1;
              rd_idx = ROW_AW'(phase_d - PH_REP_FIRST);
              nxt = {1'b0, rcount_d} + 4'd1;
              if (nxt >= scale) begin
                rcount_d = 3'd0;
                phase_d = phase_d + 5'd1;
                if (phase_d >= PH_REP_END) begin
                  fsticky_d = 1'b1;
                  fnow = 1'b1;
                  phase_d = PH_GAP_LOAD;
                end
              end else begin
                rcount_d = nxt[2:0];
              end
            end
          end
        end
        result_o.draw = drw;
        result_o.copy_done = fnow;
        result_o.finished_flag = fsticky_d;
        if (drw) begin
          result_o.row_bits = rows_q[rd_idx];
          result_o.x_start = use_x_rep ? cfg_i.x_repeat : cfg_i.x_first;
          result_o.object_color = cfg_i.sprite_color;
        end
        result_o.pixel_scale = drw ? scale : 4'd1;
      end
      ACT_STATUS: begin
        fsticky_d = 1'b0;
        result_o.pixel_scale = 4'd1;
      end
      default: begin
        result_o.pixel_scale = 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      vcount_q <= '0;
      rcount_q <= '0;
      fsticky_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      vcount_q <= vcount_d;
      rcount_q <= rcount_d;
      fsticky_q <= fsticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_wr) begin
      rows_q[item_i.row_index[ROW_AW-1:0]] <= item_i.row_data;
    end
  end

endmodule
`default_nettype wire

/* verif/tb_sprite_scanline_sequencer_top.sv */
// Self-checking testbench for sprite_scanline_sequencer_top: directed and random
// scanline, row-write and status transfers checked against a cycle-free line predictor.
// Depends on ssq_pkg and the sprite_scanline_sequencer_top RTL.
`timescale 1ns / 100ps
module tb_sprite_scanline_sequencer_top;
  import ssq_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_LINE = 311;
  localparam int ITEM_TARGET = 1250;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  ssq_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  ssq_out_t   out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  sprite_scanline_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // sequencer shadow state and register copy
  ssq_cfg_t   cfg_shadow = '0;
  logic [4:0] seq_phase = PH_IDLE;
  logic [7:0] vcount = '0;
  logic [2:0] rep_count = '0;
  logic       done_sticky = 1'b0;
  logic [7:0] row_store [ROW_COUNT];

  ssq_in_t  line_queue [$];
  ssq_out_t expected_lines [$];

  bit no_gaps = 1'b0;
  int next_line = 0;
  int errors = 0;
  int queued_items = 0;
  int items_taken = 0;
  int ticks_taken = 0;
  int draws_seen = 0;
  int copies_seen = 0;
  int settings_used = 0;

  function automatic bit row_line_done();
    int scale;
    int nxt;
    scale = 1 << cfg_shadow.size_code;
    nxt = int'(rep_count) + 1;
    if (nxt >= scale) begin
      rep_count = '0;
      return 1'b1;
    end
    rep_count = 3'(nxt);
    return 1'b0;
  endfunction

  function automatic ssq_out_t predict_line(ssq_in_t it);
    ssq_out_t r;
    int ln;
    int v;
    bit go;
    r = '0;
    ln = int'(it.line);
    case (it.action)
      ACT_ROW_WR: begin
        if (it.row_index < ROW_COUNT) row_store[it.row_index] = it.row_data;
      end
      ACT_STATUS: begin
        r.finished_flag = done_sticky;
        done_sticky = 1'b0;
      end
      ACT_TICK: begin
        if (ln == 0) begin
          vcount = cfg_shadow.y_first;
          seq_phase = PH_IDLE;
          rep_count = '0;
          done_sticky = 1'b0;
        end
        if (ln <= LAST_ACTIVE_LINE) begin
          if (seq_phase == PH_IDLE && ln == int'(vcount) + 2) seq_phase = PH_ROW_FIRST;
          if (seq_phase >= PH_ROW_FIRST && seq_phase <= PH_ROW_LAST) begin
            r.draw = 1'b1;
            r.row_bits = row_store[int'(seq_phase) - 1];
            r.x_start = cfg_shadow.x_first;
            if (row_line_done()) begin
              seq_phase = seq_phase + 5'd1;
              if (seq_phase > PH_ROW_LAST) begin
                done_sticky = 1'b1;
                r.copy_done = 1'b1;
              end
            end
          end else if (seq_phase >= PH_GAP_LOAD && seq_phase < PH_REP_END) begin
            go = 1'b1;
            if (seq_phase == PH_GAP_LOAD) begin
              v = (cfg_shadow.y_gap == GAP_NONE) ? 0 : int'(cfg_shadow.y_gap) + 1;
              vcount = 8'(v);
              if (v > int'(GAP_REPEAT_MAX)) begin
                go = 1'b0;
              end else begin
                rep_count = '0;
                seq_phase = PH_GAP_WAIT;
              end
            end
            if (go && seq_phase == PH_GAP_WAIT) begin
              if (vcount != 8'd0) begin
                vcount = vcount - 8'd1;
                go = 1'b0;
              end else begin
                seq_phase = PH_REP_FIRST;
              end
            end
            if (go && seq_phase >= PH_REP_FIRST && seq_phase < PH_REP_END) begin
              r.draw = 1'b1;
              r.row_bits = row_store[int'(seq_phase) - int'(PH_REP_FIRST)];
              r.x_start = cfg_shadow.x_repeat;
              if (row_line_done()) begin
                seq_phase = seq_phase + 5'd1;
                if (seq_phase >= PH_REP_END) begin
                  done_sticky = 1'b1;
                  r.copy_done = 1'b1;
                  seq_phase = PH_GAP_LOAD;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (it.action != ACT_STATUS) r.finished_flag = done_sticky;
    r.pixel_scale = r.draw ? 4'(1 << cfg_shadow.size_code) : 4'd1;
    r.object_color = r.draw ? cfg_shadow.sprite_color : 3'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 50) $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
  endtask

  task automatic check_result(ssq_out_t got, ssq_out_t want);
    if (got.draw !== want.draw) report_mismatch("draw", got.draw, want.draw);
    if (got.row_bits !== want.row_bits) report_mismatch("row_bits", got.row_bits, want.row_bits);
    if (got.x_start !== want.x_start) report_mismatch("x_start", got.x_start, want.x_start);
    if (got.pixel_scale !== want.pixel_scale)
      report_mismatch("pixel_scale", got.pixel_scale, want.pixel_scale);
    if (got.object_color !== want.object_color)
      report_mismatch("object_color", got.object_color, want.object_color);
    if (got.copy_done !== want.copy_done)
      report_mismatch("copy_done", got.copy_done, want.copy_done);
    if (got.finished_flag !== want.finished_flag)
      report_mismatch("finished_flag", got.finished_flag, want.finished_flag);
  endtask

  // driver: predict on each input transfer, then hold or advance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_lines.push_back(predict_line(in_data_i));
        items_taken++;
        if (in_data_i.action == ACT_TICK) ticks_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (line_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
          in_valid_i <= 1'b1;
          in_data_i <= line_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          if (expected_lines[0].draw) draws_seen++;
          if (expected_lines[0].copy_done) copies_seen++;
          check_result(out_data_o, expected_lines.pop_front());
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 36);
    end
  end

  task automatic push_item(logic [1:0] act, int ln, int idx, int data);
    ssq_in_t it;
    it.action = act;
    it.line = 9'(ln);
    it.row_index = 4'(idx);
    it.row_data = 8'(data);
    line_queue.push_back(it);
    queued_items++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (line_queue.size() != 0 || in_valid_i || expected_lines.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_X_FIRST:      cfg_shadow.x_first = val;
      CFG_Y_FIRST:      cfg_shadow.y_first = val;
      CFG_X_REPEAT:     cfg_shadow.x_repeat = val;
      CFG_Y_GAP:        cfg_shadow.y_gap = val;
      CFG_SIZE_CODE:    cfg_shadow.size_code = val[1:0];
      CFG_SPRITE_COLOR: cfg_shadow.sprite_color = val[2:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(int xf, int yf, int xr, int gap, int size, int color);
    write_reg(CFG_X_FIRST, 8'(xf));
    write_reg(CFG_Y_FIRST, 8'(yf));
    write_reg(CFG_X_REPEAT, 8'(xr));
    write_reg(CFG_Y_GAP, 8'(gap));
    write_reg(CFG_SIZE_CODE, 8'(size));
    write_reg(CFG_SPRITE_COLOR, 8'(color));
    settings_used++;
  endtask

  task automatic queue_frame(int count, bit from_zero);
    int r;
    int idx;
    if (from_zero) next_line = 0;
    for (int i = 0; i < count && queued_items < ITEM_TARGET; i++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        push_item(ACT_TICK, next_line, $urandom_range(0, 15), $urandom_range(0, 255));
        next_line = (next_line == MAX_LINE) ? 0 : next_line + 1;
      end else if (r < 86) begin
        idx = $urandom_range(0, 15);
        push_item(ACT_ROW_WR, $urandom_range(0, MAX_LINE), idx, $urandom_range(0, 255));
      end else if (r < 92) begin
        push_item(ACT_STATUS, $urandom_range(0, MAX_LINE), $urandom_range(0, 15),
                  $urandom_range(0, 255));
      end else if (r < 94) begin
        push_item(ACT_UNUSED, $urandom_range(0, MAX_LINE), $urandom_range(0, 15),
                  $urandom_range(0, 255));
      end else begin
        push_item(ACT_TICK, $urandom_range(0, MAX_LINE), $urandom_range(0, 15),
                  $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    int p;
    int yf;
    int gap;
    int size;
    int r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill every row before any tick can fetch one
    push_item(ACT_ROW_WR, 0, 0, 8'hFF);
    push_item(ACT_ROW_WR, 0, 1, 8'h00);
    push_item(ACT_ROW_WR, 0, 2, 8'h80);
    push_item(ACT_ROW_WR, 0, 3, 8'h01);
    push_item(ACT_ROW_WR, 0, 4, 8'hAA);
    push_item(ACT_ROW_WR, 0, 5, 8'h55);
    for (int i = 6; i < ROW_COUNT; i++) push_item(ACT_ROW_WR, 0, i, $urandom_range(0, 255));
    push_item(ACT_ROW_WR, MAX_LINE, 15, 8'h5A);
    push_item(ACT_UNUSED, MAX_LINE, 15, 8'hFF);
    push_item(ACT_STATUS, 0, 0, 0);
    for (int ln = 0; ln <= 11; ln++) push_item(ACT_TICK, ln, 0, 0);
    push_item(ACT_STATUS, 0, 0, 0);
    push_item(ACT_TICK, MAX_LINE, 0, 0);
    wait_drained();

    p = 0;
    while (queued_items < ITEM_TARGET) begin
      no_gaps = (p == 2);
      case (p)
        0: begin
          apply_setting(255, 255, 0, 255, 3, 7);
          queue_frame(330, 1'b1);
        end
        1: begin
          apply_setting(0, 0, 255, 253, 0, 0);
          queue_frame(120, 1'b1);
        end
        2: begin
          apply_setting($urandom_range(0, 255), 3, $urandom_range(0, 255), 0, 1, 5);
          queue_frame(200, 1'b1);
        end
        default: begin
          yf = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 30) : $urandom_range(0, 255);
          r = $urandom_range(0, 9);
          gap = (r < 5) ? $urandom_range(0, 8) :
                (r < 7) ? $urandom_range(252, 255) : $urandom_range(0, 255);
          r = $urandom_range(0, 9);
          size = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
          apply_setting($urandom_range(0, 255), yf, $urandom_range(0, 255), gap, size,
                        $urandom_range(0, 7));
          queue_frame((yf > 150) ? 330 : $urandom_range(80, 200), $urandom_range(0, 9) < 7);
        end
      endcase
      wait_drained();
      p++;
    end
    no_gaps = 1'b0;

    repeat (10) @(posedge clk_i);
    if (expected_lines.size() != 0) report_mismatch("results missing", expected_lines.size(), 0);

    $display("Covered %0d transfers in, %0d of them scanline ticks, under %0d register settings.",
             items_taken, ticks_taken, settings_used);
    $display("Saw %0d drawn rows and %0d completed copies; %0d mismatches.",
             draws_seen, copies_seen, errors);
    if (errors == 0) begin
      $display("[sprite_scanline_sequencer_top] OK");
    end else begin
      $display("[sprite_scanline_sequencer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sprite_scanline_sequencer_top] ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ssq_pkg.sv
rtl/ssq_seq.sv
rtl/sprite_scanline_sequencer_top.sv
verif/tb_sprite_scanline_sequencer_top.sv
